>>> hw/rtl/assert_macros.svh
// Assertion macros used by the top level of the tour move evaluator.
// Depends on nothing; the bodies vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, cond, nxt) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, nxt)
`endif
`endif

>>> hw/rtl/tsp_pkg.sv
// Package of the tour move evaluator: payload structs, operation codes,
// sizing constants and the command and status types between controller and datapath.
`default_nettype none
package tsp_pkg;
	localparam int unsigned MAX_CITIES = 64;
	localparam int unsigned MAX_SOLUTIONS = 32;
	localparam int unsigned DIST_BITS = 16;

	localparam int unsigned COST_BITS = 22;
	localparam int unsigned TRIAL_BITS = 16;
	localparam logic [COST_BITS-1:0] COST_MAX = '1;
	localparam logic [TRIAL_BITS-1:0] TRIAL_MAX = '1;

	localparam logic [2:0] OP_WR_DIST = 3'd0;
	localparam logic [2:0] OP_WR_CITY = 3'd1;
	localparam logic [2:0] OP_EVAL = 3'd2;
	localparam logic [2:0] OP_SWAP = 3'd3;
	localparam logic [2:0] OP_REV = 3'd4;

	localparam logic [1:0] REG_CITY_COUNT = 2'd0;

	typedef struct packed {
		logic [2:0] operation;
		logic [4:0] solution_index;
		logic [5:0] position_a;
		logic [5:0] position_b;
		logic [5:0] city;
		logic [15:0] distance_value;
	} in_item_t;

	typedef struct packed {
		logic [4:0] result_solution;
		logic [21:0] tour_cost;
		logic accepted;
		logic [15:0] trial_count;
	} out_item_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic latch;      // capture the input item
		logic wr_dist;    // write the distance entry
		logic wr_city;    // write one tour city
		logic load_rd;    // read the tour entry feeding candidate entry count
		logic load_wr;    // place the read entry into the candidate
		logic cost_clr;   // clear the sum
		logic cost_rd;    // issue the reads of one edge
		logic cost_acc;   // add one distance
		logic commit;     // decide and update cost and counter
		logic copy_wr;    // write one candidate entry back
		logic cnt_clr;    // clear the step counter
		logic cnt_inc;    // step the counter
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic in_range;   // move positions below city count
		logic last;       // counter at final step
		logic keep;       // move improved the cost
	} status_t;
endpackage
`default_nettype wire

>>> hw/rtl/tsp_ctrl.sv
// Controller state machine of the tour move evaluator.
// Depends on tsp_pkg for the command and status types.
`default_nettype none
module tsp_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_fire,
	input wire logic out_fire,
	input wire tsp_pkg::status_t sts,
	output tsp_pkg::cmd_t cmd,
	output logic busy,
	output logic out_load
);
	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_DEC  = 9'b000000010,
		S_LRD  = 9'b000000100,
		S_LWR  = 9'b000001000,
		S_CRD  = 9'b000010000,
		S_CWT  = 9'b000100000,
		S_CACC = 9'b001000000,
		S_COPY = 9'b010000000,
		S_OUT  = 9'b100000000
	} state_t;
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		out_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					cmd.latch = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				cmd.cnt_clr = 1'b1;
				cmd.cost_clr = 1'b1;
				case (sts.op)
					tsp_pkg::OP_WR_DIST: begin
						cmd.wr_dist = 1'b1;
						out_load = 1'b1;
						state_d = S_OUT;
					end
					tsp_pkg::OP_WR_CITY: begin
						cmd.wr_city = 1'b1;
						out_load = 1'b1;
						state_d = S_OUT;
					end
					tsp_pkg::OP_EVAL: state_d = S_LRD;
					tsp_pkg::OP_SWAP, tsp_pkg::OP_REV: begin
						if (sts.in_range) state_d = S_LRD;
						else begin
							out_load = 1'b1;
							state_d = S_OUT;
						end
					end
					default: begin
						out_load = 1'b1;
						state_d = S_OUT;
					end
				endcase
			end
			S_LRD: begin
				cmd.load_rd = 1'b1;
				state_d = S_LWR;
			end
			S_LWR: begin
				cmd.load_wr = 1'b1;
				if (sts.last) begin
					cmd.cnt_clr = 1'b1;
					state_d = S_CRD;
				end else begin
					cmd.cnt_inc = 1'b1;
					state_d = S_LRD;
				end
			end
			S_CRD: begin
				cmd.cost_rd = 1'b1;
				state_d = S_CWT;
			end
			S_CWT: state_d = S_CACC;
			S_CACC: begin
				cmd.cost_acc = 1'b1;
				if (sts.last) begin
					cmd.cnt_clr = 1'b1;
					state_d = S_COPY;
				end else begin
					cmd.cnt_inc = 1'b1;
					state_d = S_CRD;
				end
			end
			S_COPY: begin
				// First cycle of this state decides; the sum settled in CACC.
				if (sts.op == tsp_pkg::OP_EVAL || !sts.keep) begin
					cmd.commit = 1'b1;
					out_load = 1'b1;
					state_d = S_OUT;
				end else begin
					cmd.copy_wr = 1'b1;
					if (sts.last) begin
						cmd.commit = 1'b1;
						out_load = 1'b1;
						state_d = S_OUT;
					end else cmd.cnt_inc = 1'b1;
				end
			end
			S_OUT: begin
				if (out_fire) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);
endmodule
`default_nettype wire

>>> hw/rtl/tsp_dp.sv
// Datapath of the tour move evaluator: distance and tour memories, the
// candidate tour, cost accumulator, cost and counter stores.
// Depends on tsp_pkg for payload, command and status types and the sizes.
`default_nettype none
module tsp_dp (
	input wire logic clk,
	input wire logic arst_n,
	input wire tsp_pkg::in_item_t in_item,
	input wire logic [6:0] city_count,
	input wire tsp_pkg::cmd_t cmd,
	input wire logic out_load,
	output tsp_pkg::status_t sts,
	output tsp_pkg::out_item_t out_item
);
	localparam int unsigned MAX_CITIES = tsp_pkg::MAX_CITIES;
	localparam int unsigned MAX_SOLUTIONS = tsp_pkg::MAX_SOLUTIONS;
	localparam int unsigned DIST_BITS = tsp_pkg::DIST_BITS;
	localparam int unsigned CB = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
	localparam int unsigned SB = (MAX_SOLUTIONS > 1) ? $clog2(MAX_SOLUTIONS) : 1;
	localparam int unsigned NB = CB + 1;

	tsp_pkg::in_item_t item_q;
	logic [DIST_BITS-1:0] dist_mem [MAX_CITIES*MAX_CITIES];
	logic [CB-1:0] tour_mem [MAX_SOLUTIONS*MAX_CITIES];
	logic [CB-1:0] cand_q [MAX_CITIES];
	logic [tsp_pkg::COST_BITS-1:0] cost_mem [MAX_SOLUTIONS];
	logic [tsp_pkg::TRIAL_BITS-1:0] trial_q [MAX_SOLUTIONS];
	logic [CB-1:0] tour_rd_q;
	logic [DIST_BITS-1:0] dist_rd_q;
	logic [CB-1:0] from_q, to_q;
	logic [tsp_pkg::COST_BITS:0] sum_q;
	logic [NB-1:0] cnt_q;
	logic [NB-1:0] n_act;
	logic [CB-1:0] pa, pb, lo, hi, src, nxt;
	logic [SB-1:0] sol;
	logic [tsp_pkg::COST_BITS-1:0] cost_new, cur_cost;
	logic [tsp_pkg::TRIAL_BITS-1:0] cur_trial;
	logic keep;
	logic acc_q;

	assign pa = item_q.position_a[CB-1:0];
	assign pb = item_q.position_b[CB-1:0];
	assign sol = SB'(item_q.solution_index % MAX_SOLUTIONS);
	assign lo = (pa < pb) ? pa : pb;
	assign hi = (pa < pb) ? pb : pa;

	always_comb begin
		if (city_count < 7'd2) n_act = NB'(2);
		else if (32'(city_count) > MAX_CITIES) n_act = NB'(MAX_CITIES);
		else n_act = NB'(city_count);
	end

	// Source position feeding candidate entry cnt under the current move.
	always_comb begin
		src = cnt_q[CB-1:0];
		if (item_q.operation == tsp_pkg::OP_SWAP) begin
			if (cnt_q[CB-1:0] == pa) src = pb;
			else if (cnt_q[CB-1:0] == pb) src = pa;
		end else if (item_q.operation == tsp_pkg::OP_REV) begin
			if (cnt_q[CB-1:0] >= lo && cnt_q[CB-1:0] <= hi)
				src = CB'(({1'b0, lo} + {1'b0, hi}) - {1'b0, cnt_q[CB-1:0]});
		end
		nxt = (cnt_q + 1'b1 == n_act) ? '0 : CB'(cnt_q + 1'b1);
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) item_q <= in_item;
		if (cmd.wr_dist)
			dist_mem[{item_q.position_a[CB-1:0], item_q.position_b[CB-1:0]}] <=
				item_q.distance_value[DIST_BITS-1:0];
		if (cmd.wr_city)
			tour_mem[{sol, pa}] <= item_q.city[CB-1:0];
		if (cmd.load_rd) tour_rd_q <= tour_mem[{sol, src}];
		if (cmd.load_wr) cand_q[cnt_q[CB-1:0]] <= tour_rd_q;
		if (cmd.cost_rd) begin
			from_q <= cand_q[cnt_q[CB-1:0]];
			to_q <= cand_q[nxt];
		end
		dist_rd_q <= dist_mem[{from_q, to_q}];
		if (cmd.copy_wr) tour_mem[{sol, cnt_q[CB-1:0]}] <= cand_q[cnt_q[CB-1:0]];
		if (cmd.commit && (item_q.operation == tsp_pkg::OP_EVAL || keep))
			cost_mem[sol] <= cost_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sum_q <= '0;
			for (int i = 0; i < MAX_SOLUTIONS; i++) trial_q[i] <= '0;
		end else begin
			if (cmd.cnt_clr) cnt_q <= '0;
			else if (cmd.cnt_inc) cnt_q <= cnt_q + 1'b1;
			if (cmd.cost_clr) sum_q <= '0;
			else if (cmd.cost_acc) begin
				if (sum_q[tsp_pkg::COST_BITS]) sum_q <= sum_q;
				else sum_q <= sum_q + (tsp_pkg::COST_BITS+1)'(dist_rd_q);
			end
			if (cmd.commit && item_q.operation == tsp_pkg::OP_REV) begin
				if (keep) trial_q[sol] <= '0;
				else if (trial_q[sol] != tsp_pkg::TRIAL_MAX)
					trial_q[sol] <= trial_q[sol] + 1'b1;
			end
		end
	end

	assign cost_new = sum_q[tsp_pkg::COST_BITS] ? tsp_pkg::COST_MAX
		: sum_q[tsp_pkg::COST_BITS-1:0];
	assign cur_cost = cost_mem[sol];
	assign keep = cost_new < cur_cost;
	assign cur_trial = trial_q[sol];

	assign sts.op = item_q.operation;
	assign sts.in_range = ({1'b0, item_q.position_a} < 7'(n_act))
		&& ({1'b0, item_q.position_b} < 7'(n_act));
	assign sts.last = (cnt_q + 1'b1 == n_act);
	assign sts.keep = keep;

	// Result is sampled in the cycle after the decision so the stores have settled.
	logic pend_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pend_q <= 1'b0;
		else pend_q <= out_load;
	end
	always_ff @(posedge clk) begin
		if (out_load) acc_q <= (item_q.operation == tsp_pkg::OP_WR_DIST)
			|| (item_q.operation == tsp_pkg::OP_WR_CITY)
			|| (item_q.operation == tsp_pkg::OP_EVAL)
			|| (cmd.commit && keep);
		if (pend_q) begin
			out_item.result_solution <= item_q.solution_index;
			out_item.tour_cost <= cur_cost;
			out_item.accepted <= acc_q;
			out_item.trial_count <= cur_trial;
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/tsp_tour_move_evaluator.sv
// Top level of the tour move evaluator: APB register, handshake and the
// controller and datapath. Depends on tsp_pkg, tsp_ctrl, tsp_dp and the macros.
`default_nettype none
`include "assert_macros.svh"
// One item at a time. Evaluate, and in-range swap and reverse, first copy the
// tour into the candidate through the tour memory port, then add the closed-tour
// edges through the registered distance memory read, and a kept move writes the
// tour back one city a cycle. The result is held in an output register until
// taken; no reset clearing pass is needed.
module tsp_tour_move_evaluator (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire tsp_pkg::in_item_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output tsp_pkg::out_item_t out_data,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	logic [6:0] city_count_q;
	tsp_pkg::cmd_t cmd;
	tsp_pkg::status_t sts;
	logic busy, out_load, in_fire, out_fire, ov_q, pend_q;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) city_count_q <= 7'd64;
		else if (psel && penable && pwrite && paddr == tsp_pkg::REG_CITY_COUNT)
			city_count_q <= pwdata[6:0];
	end
	assign prdata = (paddr == tsp_pkg::REG_CITY_COUNT) ? {25'd0, city_count_q} : '0;

	// Output valid follows the decision through pend_q into ov_q, as the result register loads.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			pend_q <= out_load;
			if (pend_q) ov_q <= 1'b1;
			else if (out_fire) ov_q <= 1'b0;
		end
	end
	assign out_valid = ov_q;
	assign in_ready = !busy;
	assign in_fire = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	tsp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_fire(out_fire),
		.sts(sts), .cmd(cmd), .busy(busy), .out_load(out_load)
	);

	tsp_dp u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_data), .city_count(city_count_q),
		.cmd(cmd), .out_load(out_load), .sts(sts), .out_item(out_data)
	);

	`ASSERT_IMPL(a_no_accept_busy, clk, arst_n, in_fire |-> !out_valid)
	`ASSERT_NEXT(a_valid_after_load, clk, arst_n, pend_q, out_valid)
	`ASSERT_IMPL(a_one_cmd, clk, arst_n, $onehot0({cmd.wr_dist, cmd.wr_city, cmd.copy_wr}))
endmodule
`default_nettype wire
